FILE: hdl/shats_pkg.sv
// ----------------------------------------------------------------------------
// shats_pkg
// Types and constants shared by the strip hit accumulator with threshold scan.
// ----------------------------------------------------------------------------
package shats_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SCAN_END
    } state_t;

    // Operation codes carried in s_tuser
    localparam logic [2:0] OP_CLEAR = 3'd0;
    localparam logic [2:0] OP_INFO  = 3'd1;
    localparam logic [2:0] OP_ADD   = 3'd2;
    localparam logic [2:0] OP_SCAN  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_THRESHOLD    = 1'b0;
    localparam logic CFG_SAMPLE_COUNT = 1'b1;

    localparam logic [15:0] TIME_LATEST = 16'hFFFF;
    localparam logic [31:0] CHARGE_MAX  = 32'hFFFF_FFFF;
    localparam logic [4:0]  SAMPLE_COUNT_RESET = 5'd16;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 112;

    // Fixed part of one strip entry
    typedef struct packed {
        logic [15:0] type_mask;
        logic [31:0] charge;
        logic [15:0] hit_time;
        logic [15:0] total;
    } strip_row_t;

    // One result beat
    typedef struct packed {
        logic        none_found;
        logic        last;
        logic [15:0] sample_value;
        logic [15:0] time_out;
        logic [31:0] charge_out;
        logic [15:0] total_adc;
        logic [15:0] type_out;
        logic [9:0]  strip_out;
    } result_t;

endpackage

FILE: hdl/strip_hit_accumulator_threshold_scan.sv
// ----------------------------------------------------------------------------
// strip_hit_accumulator_threshold_scan
// Per-strip hit table with accumulate, sample add, threshold scan and readback.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                              Beat
//  -------  ---------------------------------  -----------------------------
//  input    s_tvalid s_tready s_tdata s_tuser  one operation, s_tuser = opcode
//  result   m_tvalid m_tready m_tdata m_tuser  one result, m_tuser = none_found,
//           m_tlast                            m_tlast = last
//  config   cfg_valid cfg_ready cfg_index      one register write
//           cfg_data
//
//  Strip info and add sample read the strip entry (and the sample word)
//  from the synchronous memories, then modify and write back.
//  A read fetches the strip entry and sample word, then waits for the output register.
//  A scan reads the strips of the block one at a time through the single
//  read port of the strip memory; stalls on m_tready hold the walk.
//  Clear and reset run a clearing pass over every strip memory entry with
//  s_tready low; sample words are qualified by per-strip
//  slot-used bits, so the sample memory is not swept.
// ----------------------------------------------------------------------------
module strip_hit_accumulator_threshold_scan #(
    parameter int STRIPS       = 1024,
    parameter int MAX_SAMPLES  = 16,
    parameter int BLOCK_STRIPS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // strip[9:0] type_mask[25:10] hit_time[41:26] charge[65:42]
    // sample_index[69:66] adc_value[85:70] block[89:86] zero[95:90]
    input  logic [shats_pkg::IN_DATA_W-1:0]     s_tdata,
    // opcode[2:0]
    input  logic [2:0]                          s_tuser,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // strip_out[9:0] type_out[25:10] total_adc[41:26] charge_out[73:42]
    // time_out[89:74] sample_value[105:90] zero[111:106]
    output logic [shats_pkg::OUT_DATA_W-1:0]    m_tdata,
    // none_found[0]
    output logic                                m_tuser,
    output logic                                m_tlast,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [15:0]                         cfg_data
);

    localparam int SW   = $clog2(STRIPS);
    localparam int MSW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SAW  = $clog2(STRIPS * MAX_SAMPLES);
    localparam int SCW  = ((SW > 11) ? SW : 11) + 1;
    localparam int BLW  = $clog2(BLOCK_STRIPS + 1);
    localparam int SDEPTH = STRIPS * MAX_SAMPLES;

    localparam logic [SW-1:0]  LAST_STRIP = SW'(STRIPS - 1);
    localparam logic [SAW-1:0] MS_L       = SAW'(MAX_SAMPLES);
    localparam logic [SCW-1:0] STRIPS_L   = SCW'(STRIPS);
    localparam logic [SCW-1:0] BLOCK_L    = SCW'(BLOCK_STRIPS);
    localparam logic [BLW-1:0] BLOCK_CNT  = BLW'(BLOCK_STRIPS);
    localparam logic [6:0]     MS7        = 7'(MAX_SAMPLES);

    typedef struct packed {
        shats_pkg::strip_row_t        data;
        logic [MAX_SAMPLES-1:0]       used;
    } entry_t;

    // ---------------- memories ----------------
    entry_t                   strip_mem [STRIPS];
    logic [15:0]              samp_mem  [SDEPTH];

    entry_t                   strip_rd_reg;
    logic [15:0]              samp_rd_reg;

    logic                     strip_re, strip_we;
    logic [SW-1:0]            strip_raddr, strip_waddr;
    entry_t                   strip_wdata;
    logic                     samp_re, samp_we;
    logic [SAW-1:0]           samp_raddr;
    logic [15:0]              samp_wdata;

    // ---------------- registers ----------------
    shats_pkg::state_t        state_reg, state_next;
    logic [SW-1:0]            clr_cnt_reg, clr_cnt_next;
    logic signed [15:0]       thr_reg;
    logic [4:0]               scnt_reg;
    logic [2:0]               op_reg, op_next;
    logic                     ok_reg, ok_next;
    logic [SW-1:0]            addr_reg, addr_next;
    logic [SAW-1:0]           saddr_reg, saddr_next;
    logic [15:0]              tmask_reg, tmask_next;
    logic [15:0]              time_reg, time_next;
    logic [23:0]              charge_reg, charge_next;
    logic [3:0]               slot_reg, slot_next;
    logic [15:0]              adc_reg, adc_next;
    logic [SCW-1:0]           scan_strip_reg, scan_strip_next;
    logic [BLW-1:0]           scan_left_reg, scan_left_next;
    logic                     pend_valid_reg, pend_valid_next;
    shats_pkg::result_t       pend_reg, pend_next;
    logic                     m_valid_reg, m_valid_next;
    shats_pkg::result_t       m_out_reg, m_out_next;

    // ---------------- input fields ----------------
    logic [9:0]               in_strip;
    logic [15:0]              in_tmask;
    logic [15:0]              in_time;
    logic [23:0]              in_charge;
    logic [3:0]               in_sidx;
    logic [15:0]              in_adc;
    logic [3:0]               in_block;

    assign in_strip  = s_tdata[9:0];
    assign in_tmask  = s_tdata[25:10];
    assign in_time   = s_tdata[41:26];
    assign in_charge = s_tdata[65:42];
    assign in_sidx   = s_tdata[69:66];
    assign in_adc    = s_tdata[85:70];
    assign in_block  = s_tdata[89:86];

    logic                     accept;
    logic                     out_free;
    logic [6:0]               slots_use;
    logic                     strip_ok;
    logic                     slot_ok;
    logic [SW-1:0]            in_addr;
    logic [MSW-1:0]           slot_idx;
    logic                     used_bit;
    logic [32:0]              charge_sum;
    logic                     over;
    shats_pkg::result_t       scan_res;

    assign s_tready  = (state_reg == shats_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign slots_use = ({2'b00, scnt_reg} > MS7) ? MS7 : {2'b00, scnt_reg};
    assign strip_ok  = SCW'(in_strip) < STRIPS_L;
    assign slot_ok   = {3'b000, in_sidx} < slots_use;
    assign in_addr   = SW'(in_strip);
    assign slot_idx  = MSW'(slot_reg);
    assign used_bit  = ok_reg && strip_rd_reg.used[slot_idx];
    assign charge_sum = {1'b0, strip_rd_reg.data.charge} + 33'(charge_reg);
    assign over      = $signed(strip_rd_reg.data.total) > thr_reg;

    always_comb begin
        scan_res              = '0;
        scan_res.strip_out    = 10'(scan_strip_reg);
        scan_res.type_out     = strip_rd_reg.data.type_mask;
        scan_res.total_adc    = strip_rd_reg.data.total;
        scan_res.charge_out   = strip_rd_reg.data.charge;
        scan_res.time_out     = strip_rd_reg.data.hit_time;
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        op_next         = op_reg;
        ok_next         = ok_reg;
        addr_next       = addr_reg;
        saddr_next      = saddr_reg;
        tmask_next      = tmask_reg;
        time_next       = time_reg;
        charge_next     = charge_reg;
        slot_next       = slot_reg;
        adc_next        = adc_reg;
        scan_strip_next = scan_strip_reg;
        scan_left_next  = scan_left_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_out_next      = m_out_reg;

        strip_re    = 1'b0;
        strip_raddr = in_addr;
        strip_we    = 1'b0;
        strip_waddr = addr_reg;
        strip_wdata = strip_rd_reg;
        samp_re     = 1'b0;
        samp_raddr  = SAW'(in_addr) * MS_L + SAW'(in_sidx);
        samp_we     = 1'b0;
        samp_wdata  = (used_bit ? samp_rd_reg : 16'h0000) + adc_reg;

        case (state_reg)
            shats_pkg::ST_CLEAR: begin
                strip_we                = 1'b1;
                strip_waddr             = clr_cnt_reg;
                strip_wdata.data.type_mask = '0;
                strip_wdata.data.charge    = '0;
                strip_wdata.data.hit_time  = shats_pkg::TIME_LATEST;
                strip_wdata.data.total     = '0;
                strip_wdata.used           = '0;
                clr_cnt_next            = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_STRIP) begin
                    clr_cnt_next = '0;
                    state_next   = shats_pkg::ST_IDLE;
                end
            end

            shats_pkg::ST_IDLE: begin
                if (accept) begin
                    op_next     = s_tuser;
                    addr_next   = in_addr;
                    saddr_next  = samp_raddr;
                    tmask_next  = in_tmask;
                    time_next   = in_time;
                    charge_next = in_charge;
                    slot_next   = in_sidx;
                    adc_next    = in_adc;
                    case (s_tuser)
                        shats_pkg::OP_CLEAR: begin
                            state_next = shats_pkg::ST_CLEAR;
                        end
                        shats_pkg::OP_INFO: begin
                            ok_next    = strip_ok;
                            strip_re   = 1'b1;
                            state_next = shats_pkg::ST_EXEC;
                        end
                        shats_pkg::OP_ADD, shats_pkg::OP_READ: begin
                            ok_next    = strip_ok && slot_ok;
                            strip_re   = 1'b1;
                            samp_re    = 1'b1;
                            state_next = shats_pkg::ST_EXEC;
                        end
                        shats_pkg::OP_SCAN: begin
                            scan_strip_next = SCW'(in_block) * BLOCK_L;
                            scan_left_next  = BLOCK_CNT;
                            pend_valid_next = 1'b0;
                            state_next      = shats_pkg::ST_SCAN_RD;
                        end
                        default: begin
                            state_next = shats_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            shats_pkg::ST_EXEC: begin
                case (op_reg)
                    shats_pkg::OP_INFO: begin
                        strip_we = ok_reg;
                        strip_wdata.data.type_mask =
                            strip_rd_reg.data.type_mask | tmask_reg;
                        strip_wdata.data.hit_time =
                            (time_reg < strip_rd_reg.data.hit_time) ?
                            time_reg : strip_rd_reg.data.hit_time;
                        strip_wdata.data.charge = charge_sum[32] ?
                            shats_pkg::CHARGE_MAX : charge_sum[31:0];
                        state_next = shats_pkg::ST_IDLE;
                    end
                    shats_pkg::OP_ADD: begin
                        strip_we = ok_reg;
                        samp_we  = ok_reg;
                        strip_wdata.data.total = strip_rd_reg.data.total + adc_reg;
                        strip_wdata.used[slot_idx] = 1'b1;
                        state_next = shats_pkg::ST_IDLE;
                    end
                    default: begin
                        // read sample: wait for room in the output register
                        if (out_free) begin
                            m_valid_next            = 1'b1;
                            m_out_next              = '0;
                            m_out_next.sample_value = used_bit ? samp_rd_reg : 16'h0000;
                            m_out_next.last         = 1'b1;
                            state_next              = shats_pkg::ST_IDLE;
                        end
                    end
                endcase
            end

            shats_pkg::ST_SCAN_RD: begin
                strip_raddr = SW'(scan_strip_reg);
                if (scan_left_reg == '0 || scan_strip_reg >= STRIPS_L) begin
                    state_next = shats_pkg::ST_SCAN_END;
                end else begin
                    strip_re   = 1'b1;
                    state_next = shats_pkg::ST_SCAN_CHK;
                end
            end

            shats_pkg::ST_SCAN_CHK: begin
                // hold one hit back so the final one can carry last
                if (!over || !pend_valid_reg || out_free) begin
                    if (over) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_out_next   = pend_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = scan_res;
                    end
                    scan_strip_next = scan_strip_reg + 1'b1;
                    scan_left_next  = scan_left_reg - 1'b1;
                    state_next      = shats_pkg::ST_SCAN_RD;
                end
            end

            shats_pkg::ST_SCAN_END: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (pend_valid_reg) begin
                        m_out_next      = pend_reg;
                        m_out_next.last = 1'b1;
                    end else begin
                        m_out_next            = '0;
                        m_out_next.none_found = 1'b1;
                        m_out_next.last       = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = shats_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = shats_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= shats_pkg::ST_CLEAR;
            clr_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        op_reg         <= op_next;
        ok_reg         <= ok_next;
        addr_reg       <= addr_next;
        saddr_reg      <= saddr_next;
        tmask_reg      <= tmask_next;
        time_reg       <= time_next;
        charge_reg     <= charge_next;
        slot_reg       <= slot_next;
        adc_reg        <= adc_next;
        scan_strip_reg <= scan_strip_next;
        scan_left_reg  <= scan_left_next;
        pend_reg       <= pend_next;
        m_out_reg      <= m_out_next;
    end

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= '0;
            scnt_reg <= shats_pkg::SAMPLE_COUNT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                shats_pkg::CFG_THRESHOLD:    thr_reg  <= $signed(cfg_data);
                shats_pkg::CFG_SAMPLE_COUNT: scnt_reg <= cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- memory ports ----------------
    always_ff @(posedge aclk) begin
        if (strip_we) begin
            strip_mem[strip_waddr] <= strip_wdata;
        end
        if (strip_re) begin
            strip_rd_reg <= strip_mem[strip_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (samp_we) begin
            samp_mem[saddr_reg] <= samp_wdata;
        end
        if (samp_re) begin
            samp_rd_reg <= samp_mem[samp_raddr];
        end
    end

    // ---------------- outputs ----------------
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_out_reg.none_found;
    assign m_tlast  = m_out_reg.last;
    assign m_tdata  = {6'b000000, m_out_reg.sample_value, m_out_reg.time_out,
                       m_out_reg.charge_out, m_out_reg.total_adc,
                       m_out_reg.type_out, m_out_reg.strip_out};

    // ---------------- assertions ----------------
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser <= shats_pkg::OP_READ) |=> !s_tready)
        else $error("input taken on the cycle after an accepted beat");

    a_pend_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (state_reg == shats_pkg::ST_SCAN_RD ||
                            state_reg == shats_pkg::ST_SCAN_CHK ||
                            state_reg == shats_pkg::ST_SCAN_END))
        else $error("held scan hit outside a scan");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (strip_we || samp_we) |-> (state_reg == shats_pkg::ST_CLEAR ||
                                   state_reg == shats_pkg::ST_EXEC))
        else $error("table written outside clear or update");

    a_none_found_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("none-found beat without last");

endmodule
